>>> hw/rtl/irpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpw_pkg: shared types and constants of the IR pulse width frame decoder
// Register indexes, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package irpw_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int TIME_W      = 32;
	localparam int THR_W       = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_GAP_TIMEOUT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ONE_THRESHOLD  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ZERO_THRESHOLD = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_START_LIMIT    = 2'd3;

	localparam logic [TIME_W-1:0] GAP_TIMEOUT_RST    = 32'd100000;
	localparam logic [THR_W-1:0]  ONE_THRESHOLD_RST  = 16'd1500;
	localparam logic [THR_W-1:0]  ZERO_THRESHOLD_RST = 16'd450;
	localparam logic [THR_W-1:0]  START_LIMIT_RST    = 16'd4000;

	localparam logic MODE_EDGE = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] gap_timeout;
		logic [THR_W-1:0]  one_threshold;
		logic [THR_W-1:0]  zero_threshold;
		logic [THR_W-1:0]  start_limit;
	} cfg_t;

	// Classification of one edge against the previous edge time
	typedef struct packed {
		logic wrapped;
		logic timeout;
		logic record;
		logic is_one;
		logic too_short;
	} edge_cls_t;

endpackage

>>> hw/rtl/irpw_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpw_cfg_regs: configuration register file
// Four timing registers written through a valid/ready write channel.
// ----------------------------------------------------------------------------
module irpw_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [irpw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [irpw_pkg::TIME_W-1:0]       cfg_data,
	output irpw_pkg::cfg_t                    cfg
);

	irpw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_timeout    <= irpw_pkg::GAP_TIMEOUT_RST;
			cfg_q.one_threshold  <= irpw_pkg::ONE_THRESHOLD_RST;
			cfg_q.zero_threshold <= irpw_pkg::ZERO_THRESHOLD_RST;
			cfg_q.start_limit    <= irpw_pkg::START_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				irpw_pkg::REG_GAP_TIMEOUT:    cfg_q.gap_timeout    <= cfg_data;
				irpw_pkg::REG_ONE_THRESHOLD:  cfg_q.one_threshold  <=
					cfg_data[irpw_pkg::THR_W-1:0];
				irpw_pkg::REG_ZERO_THRESHOLD: cfg_q.zero_threshold <=
					cfg_data[irpw_pkg::THR_W-1:0];
				irpw_pkg::REG_START_LIMIT:    cfg_q.start_limit    <=
					cfg_data[irpw_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/irpw_edge_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpw_edge_classify: pulse duration measurement
// Subtracts the previous edge time and compares the duration at full width.
// ----------------------------------------------------------------------------
module irpw_edge_classify (
	input  logic [irpw_pkg::TIME_W-1:0] edge_time,
	input  logic [irpw_pkg::TIME_W-1:0] last_edge_time,
	input  logic                        pin_level,
	input  irpw_pkg::cfg_t              cfg,
	output irpw_pkg::edge_cls_t         cls
);

	logic [irpw_pkg::TIME_W-1:0] dur;

	always_comb begin
		dur           = edge_time - last_edge_time;
		cls.wrapped   = last_edge_time > edge_time;
		cls.timeout   = dur > cfg.gap_timeout;
		cls.record    = !pin_level &&
			(dur < {{(irpw_pkg::TIME_W-irpw_pkg::THR_W){1'b0}}, cfg.start_limit});
		cls.is_one    = dur > {{(irpw_pkg::TIME_W-irpw_pkg::THR_W){1'b0}},
			cfg.one_threshold};
		// a one wins even when the thresholds are out of order
		cls.too_short = !cls.is_one &&
			(dur <= {{(irpw_pkg::TIME_W-irpw_pkg::THR_W){1'b0}}, cfg.zero_threshold});
	end

endmodule

>>> hw/rtl/irpw_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpw_frame_fsm: frame state and result register
// Collects bits of one frame, holds it for a read, and registers read results.
// ----------------------------------------------------------------------------
module irpw_frame_fsm #(
	parameter int FRAME_BITS = 32,
	parameter int KEY_BITS   = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic                        mode,
	input  logic [irpw_pkg::TIME_W-1:0] edge_time,
	input  logic                        pin_level,
	input  irpw_pkg::edge_cls_t         cls,
	input  logic                        out_ready,
	output logic [irpw_pkg::TIME_W-1:0] last_edge_time,
	output logic                        out_valid,
	output logic [KEY_BITS-1:0]         key,
	output logic                        frame_ready,
	output logic                        parse_error
);

	localparam int POS_W = $clog2(FRAME_BITS);
	localparam int FIRST = FRAME_BITS - KEY_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RECV,
		ST_WAIT
	} state_t;

	state_t                      state_q;
	logic [POS_W-1:0]            pos_q;
	logic [irpw_pkg::TIME_W-1:0] last_q;
	logic [KEY_BITS-1:0]         bits_q;
	logic                        invalid_q;
	logic                        out_valid_q;
	logic [KEY_BITS-1:0]         key_q;
	logic                        ready_q;
	logic                        error_q;

	logic [POS_W:0]              pos_next;
	logic [KEY_BITS-1:0]         bit_set;

	always_comb begin
		pos_next = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
		for (int i = 0; i < KEY_BITS; i++) begin
			bit_set[i] = cls.is_one && (FIRST >= 0) && (int'(pos_q) == FIRST + i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			last_q      <= '0;
			bits_q      <= '0;
			invalid_q   <= 1'b0;
			out_valid_q <= 1'b0;
			key_q       <= '0;
			ready_q     <= 1'b0;
			error_q     <= 1'b0;
		end else begin
			if (go && mode == irpw_pkg::MODE_READ) begin
				out_valid_q <= 1'b1;
				ready_q     <= (state_q == ST_WAIT);
				error_q     <= (state_q == ST_WAIT) && invalid_q;
				key_q       <= (state_q == ST_WAIT && !invalid_q) ? bits_q : '0;
				if (state_q == ST_WAIT) begin
					state_q   <= ST_IDLE;
					pos_q     <= '0;
					bits_q    <= '0;
					invalid_q <= 1'b0;
				end
			end else begin
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
				if (go) begin
					unique case (state_q)
						ST_WAIT: ;
						ST_IDLE: begin
							if (!pin_level) begin
								state_q   <= ST_RECV;
								pos_q     <= '0;
								bits_q    <= '0;
								invalid_q <= 1'b0;
							end
							last_q <= edge_time;
						end
						ST_RECV: begin
							last_q <= edge_time;
							if (cls.wrapped) begin
								pos_q     <= '0;
								bits_q    <= '0;
								invalid_q <= 1'b0;
							end else if (cls.timeout) begin
								// abandon the frame; this edge does not start a new one
								state_q   <= ST_IDLE;
								pos_q     <= '0;
								bits_q    <= '0;
								invalid_q <= 1'b0;
							end else if (cls.record) begin
								invalid_q <= invalid_q | cls.too_short;
								bits_q    <= bits_q | bit_set;
								if (int'(pos_next) >= FRAME_BITS) begin
									state_q <= ST_WAIT;
									pos_q   <= '0;
								end else begin
									pos_q <= pos_next[POS_W-1:0];
								end
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
			end
		end
	end

	assign last_edge_time = last_q;
	assign out_valid      = out_valid_q;
	assign key            = key_q;
	assign frame_ready    = ready_q;
	assign parse_error    = error_q;

endmodule

>>> hw/rtl/ir_pulse_width_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_decoder: pulse distance IR remote frame decoder
// Decodes timestamped pin edges into a key and answers key read requests.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_ready  | mode, edge_time, pin_level
//   out     | output    | out_valid / out_ready| key, frame_ready, parse_error
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle unless a read is held: a transfer lands in the input
// register, and from there the frame logic updates its state and, for a read,
// loads the result register. Reset restores the default timings and returns
// the decoder to idle. A read stalls in the input register only while the
// result register is full and not taken; edge events pass regardless.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_decoder #(
	parameter int FRAME_BITS = 32,
	parameter int KEY_BITS   = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [irpw_pkg::TIME_W-1:0]       edge_time,
	input  logic                              pin_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [KEY_BITS-1:0]               key,
	output logic                              frame_ready,
	output logic                              parse_error,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [irpw_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [irpw_pkg::TIME_W-1:0]       cfg_data
);

	irpw_pkg::cfg_t              cfg;
	irpw_pkg::edge_cls_t         cls;
	logic                        valid_s1;
	logic                        mode_s1;
	logic [irpw_pkg::TIME_W-1:0] time_s1;
	logic                        level_s1;
	logic [irpw_pkg::TIME_W-1:0] last_edge_time;
	logic                        go;

	// hold a read only while the result register cannot take it
	assign go       = valid_s1 &&
		!(mode_s1 == irpw_pkg::MODE_READ && out_valid && !out_ready);
	assign in_ready = !valid_s1 || go;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_s1  <= irpw_pkg::MODE_EDGE;
			time_s1  <= '0;
			level_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			mode_s1  <= mode;
			time_s1  <= edge_time;
			level_s1 <= pin_level;
		end
	end

	irpw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	irpw_edge_classify u_cls (
		.edge_time      (time_s1),
		.last_edge_time (last_edge_time),
		.pin_level      (level_s1),
		.cfg            (cfg),
		.cls            (cls)
	);

	irpw_frame_fsm #(
		.FRAME_BITS (FRAME_BITS),
		.KEY_BITS   (KEY_BITS)
	) u_fsm (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (go),
		.mode           (mode_s1),
		.edge_time      (time_s1),
		.pin_level      (level_s1),
		.cls            (cls),
		.out_ready      (out_ready),
		.last_edge_time (last_edge_time),
		.out_valid      (out_valid),
		.key            (key),
		.frame_ready    (frame_ready),
		.parse_error    (parse_error)
	);

endmodule

>>> test/tb_ir_pulse_width_frame_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ir_pulse_width_frame_decoder: regression of the IR pulse width decoder
// Sends edge events and key reads under random handshake pressure. It first
// walks a short table of corner cases and then sends random remote frames and
// noise under several timing settings. Table reads expect a given result;
// other key reads are checked against a behavioral decoder in this bench.
// ----------------------------------------------------------------------------
module tb_ir_pulse_width_frame_decoder;
	import irpw_pkg::*;

	localparam int FRAME_LEN   = 32;
	localparam int KEY_LEN     = 15;
	localparam int KEY_FIRST   = FRAME_LEN - KEY_LEN;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 155;
	localparam int SETTLE      = 8;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic [KEY_LEN-1:0] key;
		logic               frame_ready;
		logic               parse_error;
	} key_read_t;

	typedef struct packed {
		logic              mode;
		logic [TIME_W-1:0] t;
		logic              level;
		logic              typed;
		key_read_t         res;
	} dir_row_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic                   mode        = MODE_EDGE;
	logic [TIME_W-1:0]      edge_time   = '0;
	logic                   pin_level   = 1'b0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic [KEY_LEN-1:0]     key;
	logic                   frame_ready;
	logic                   parse_error;
	logic                   cfg_valid   = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index   = REG_GAP_TIMEOUT;
	logic [TIME_W-1:0]      cfg_data    = '0;

	// behavioral decoder state
	cfg_t                   dec_cfg = '{GAP_TIMEOUT_RST, ONE_THRESHOLD_RST,
	                                    ZERO_THRESHOLD_RST, START_LIMIT_RST};
	bit                     dec_rx;
	bit                     dec_held;
	bit                     dec_bad;
	int unsigned            dec_pos;
	logic [TIME_W-1:0]      dec_last;
	logic [KEY_LEN-1:0]     dec_key;

	key_read_t              reads_due[$];
	dir_row_t               dir_rows[$];
	int                     fail_count;
	int                     item_count;
	int                     read_count;
	int                     ready_count;
	int                     bad_count;
	int                     stall_cycles;
	int                     src_idle_pct = 13;
	int                     snk_idle_pct = 72;

	ir_pulse_width_frame_decoder #(
		.FRAME_BITS(FRAME_LEN),
		.KEY_BITS  (KEY_LEN)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.edge_time  (edge_time),
		.pin_level  (pin_level),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key        (key),
		.frame_ready(frame_ready),
		.parse_error(parse_error),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the decoder by one accepted event; a read yields one result.
	task automatic decode_step(input logic m, input logic [TIME_W-1:0] t, input logic lvl,
			output bit got, output key_read_t r);
		logic [TIME_W-1:0] d;
		bit                is_one;
		got = 1'b0;
		r = '0;
		d = t - dec_last;
		if (m == MODE_READ) begin
			got = 1'b1;
			if (dec_held) begin
				r.frame_ready = 1'b1;
				r.parse_error = dec_bad;
				r.key = dec_bad ? '0 : dec_key;
				dec_held = 1'b0;
				dec_pos = 0;
				dec_key = '0;
				dec_bad = 1'b0;
			end
		end else if (dec_held) begin
			// edges are dropped while a frame waits for its read
		end else if (!dec_rx) begin
			if (!lvl) begin
				dec_rx = 1'b1;
				dec_pos = 0;
				dec_key = '0;
				dec_bad = 1'b0;
			end
			dec_last = t;
		end else if (dec_last > t) begin
			dec_pos = 0;
			dec_key = '0;
			dec_bad = 1'b0;
			dec_last = t;
		end else begin
			if (d > dec_cfg.gap_timeout) begin
				dec_rx = 1'b0;
				dec_pos = 0;
				dec_key = '0;
				dec_bad = 1'b0;
			end else if (!lvl && d < dec_cfg.start_limit) begin
				is_one = d > dec_cfg.one_threshold;
				if (!is_one && d <= dec_cfg.zero_threshold)
					dec_bad = 1'b1;
				if (is_one && dec_pos >= KEY_FIRST)
					dec_key[dec_pos - KEY_FIRST] = 1'b1;
				dec_pos++;
				if (dec_pos == FRAME_LEN) begin
					dec_held = 1'b1;
					dec_rx = 1'b0;
					dec_pos = 0;
				end
			end
			dec_last = t;
		end
	endtask

	task automatic send_event(input logic m, input logic [TIME_W-1:0] t, input logic lvl,
			input bit typed, input key_read_t typed_res);
		bit        got;
		key_read_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		edge_time <= t;
		pin_level <= lvl;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		decode_step(m, t, lvl, got, r);
		item_count++;
		if (got) begin
			reads_due.push_back(typed ? typed_res : r);
			read_count++;
			if (r.frame_ready) ready_count++;
			if (r.parse_error) bad_count++;
		end
	endtask

	task automatic program_timing(input cfg_t c);
		logic [CFG_INDEX_W-1:0] regs[4];
		logic [TIME_W-1:0]      vals[4];
		regs = '{REG_GAP_TIMEOUT, REG_ONE_THRESHOLD, REG_ZERO_THRESHOLD, REG_START_LIMIT};
		vals = '{c.gap_timeout, TIME_W'(c.one_threshold), TIME_W'(c.zero_threshold),
		         TIME_W'(c.start_limit)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			case (regs[i])
				REG_GAP_TIMEOUT:    dec_cfg.gap_timeout    = vals[i];
				REG_ONE_THRESHOLD:  dec_cfg.one_threshold  = vals[i][THR_W-1:0];
				REG_ZERO_THRESHOLD: dec_cfg.zero_threshold = vals[i][THR_W-1:0];
				default:            dec_cfg.start_limit    = vals[i][THR_W-1:0];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Hold input off until every read has come back and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (reads_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One remote frame shaped to the current timings, with random bits.
	task automatic send_frame();
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] mk_max;
		logic [TIME_W-1:0] upper;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		int                cls;
		if (dec_held)
			send_event(MODE_READ, $urandom, 1'($urandom_range(1)), 1'b0, '0);
		// step back in time to restart an open frame, else start from idle
		if (dec_rx && dec_last != 0)
			t = $urandom_range(dec_last - 1, 0);
		else
			t = $urandom;
		send_event(MODE_EDGE, t, 1'b0, 1'b0, '0);
		mk_max = (dec_cfg.gap_timeout < 700) ? dec_cfg.gap_timeout : 700;
		if ($urandom_range(1) && dec_cfg.start_limit <= dec_cfg.gap_timeout) begin
			t += $urandom_range(mk_max, 0);
			send_event(MODE_EDGE, t, 1'b1, 1'b0, '0);
			hi = dec_cfg.gap_timeout - dec_cfg.start_limit;
			t += dec_cfg.start_limit + $urandom_range((hi < 500) ? hi : 500, 0);
			send_event(MODE_EDGE, t, 1'b0, 1'b0, '0);
		end
		for (int b = 0; b < FRAME_LEN; b++) begin
			t += $urandom_range(mk_max, 0);
			send_event(MODE_EDGE, t, 1'b1, 1'b0, '0);
			if (dec_cfg.start_limit == 0) begin
				lo = 0;
				hi = mk_max;
			end else begin
				upper = dec_cfg.start_limit - 1;
				if (dec_cfg.gap_timeout < upper) upper = dec_cfg.gap_timeout;
				cls = $urandom_range(99);
				if (cls < 4) begin
					lo = 0;
					hi = dec_cfg.zero_threshold;
				end else if (cls < 52) begin
					lo = dec_cfg.one_threshold + 32'd1;
					hi = upper;
				end else begin
					lo = dec_cfg.zero_threshold + 32'd1;
					hi = dec_cfg.one_threshold;
				end
				if (hi > upper) hi = upper;
				if (lo > hi) begin
					lo = 0;
					hi = upper;
				end
			end
			t += $urandom_range(hi, lo);
			send_event(MODE_EDGE, t, 1'b0, 1'b0, '0);
		end
		repeat ($urandom_range(2))
			send_event(MODE_EDGE, $urandom, 1'($urandom_range(1)), 1'b0, '0);
		if ($urandom_range(9) < 8)
			send_event(MODE_READ, $urandom, 1'($urandom_range(1)), 1'b0, '0);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	always @(posedge clk) begin
		key_read_t want;
		if (arst_n && out_valid && out_ready) begin
			if (reads_due.size() == 0) begin
				$error("result with no read pending: key %0d frame_ready %0d parse_error %0d",
				       key, frame_ready, parse_error);
				fail_count++;
			end else begin
				want = reads_due.pop_front();
				if (key !== want.key) begin
					$error("key: expected %0d, actual %0d", want.key, key);
					fail_count++;
				end
				if (frame_ready !== want.frame_ready) begin
					$error("frame_ready: expected %0d, actual %0d", want.frame_ready, frame_ready);
					fail_count++;
				end
				if (parse_error !== want.parse_error) begin
					$error("parse_error: expected %0d, actual %0d", want.parse_error, parse_error);
					fail_count++;
				end
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("ir_pulse_width_frame_decoder regression: fail");
		$finish;
	end

	initial begin
		cfg_t        plan;
		int unsigned phase_start;
		// reads expect nothing waiting; the rest runs through the decoder model
		dir_rows.push_back('{MODE_READ, 32'h0000_0000, 1'b0, 1'b1, '{15'd0, 1'b0, 1'b0}});
		dir_rows.push_back('{MODE_READ, 32'hFFFF_FFFF, 1'b1, 1'b1, '{15'd0, 1'b0, 1'b0}});
		dir_rows.push_back('{MODE_EDGE, 32'hFFFF_FFFF, 1'b1, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd0,         1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd560,       1'b1, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd2250,      1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd2810,      1'b1, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd3370,      1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd3500,      1'b1, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd3700,      1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd7700,      1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd7701,      1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd7700,      1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd107700,    1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd207701,    1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd207702,    1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd208153,    1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd209653,    1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd211154,    1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd211604,    1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd215603,    1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_EDGE, 32'd282139,    1'b0, 1'b0, '0});
		dir_rows.push_back('{MODE_READ, 32'd282140,    1'b0, 1'b1, '{15'd0, 1'b0, 1'b0}});
		dir_rows.push_back('{MODE_EDGE, 32'h8000_0000, 1'b1, 1'b0, '0});
		dir_rows.push_back('{MODE_READ, 32'h5555_5555, 1'b1, 1'b1, '{15'd0, 1'b0, 1'b0}});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_event(dir_rows[i].mode, dir_rows[i].t, dir_rows[i].level,
			           dir_rows[i].typed, dir_rows[i].res);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p / 2)
				0: begin src_idle_pct = 13; snk_idle_pct = 72; end
				1: begin src_idle_pct = 72; snk_idle_pct = 13; end
				default: begin src_idle_pct = 0; snk_idle_pct = 0; end
			endcase
			case (p)
				0: plan = '{GAP_TIMEOUT_RST, ONE_THRESHOLD_RST, ZERO_THRESHOLD_RST,
				            START_LIMIT_RST};
				1: plan = '{32'd0, 16'd0, 16'd0, 16'd0};
				2: plan = '{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
				// zero threshold above the one threshold
				3: plan = '{$urandom_range(200000, 20000), 16'($urandom_range(600, 200)),
				            16'($urandom_range(1400, 700)), 16'($urandom_range(6000, 3000))};
				4: plan = '{$urandom_range(200000, 5000), 16'($urandom_range(2000, 1000)),
				            16'($urandom_range(600, 200)), 16'($urandom_range(10000, 3000))};
				default: plan = '{$urandom, 16'($urandom), 16'($urandom), 16'($urandom)};
			endcase
			program_timing(plan);
			phase_start = item_count;
			while (item_count - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(99) < 70)
					send_frame();
				else
					repeat ($urandom_range(6, 1))
						send_event(($urandom_range(99) < 30) ? MODE_READ : MODE_EDGE,
						           $urandom, 1'($urandom_range(1)), 1'b0, '0);
			end
			drain();
		end

		$display("covered %0d input transfers over %0d timing settings", item_count, PHASES + 1);
		$display("checked %0d key reads: %0d with a frame waiting, %0d of them bad",
		         read_count, ready_count, bad_count);
		if (fail_count == 0)
			$display("ir_pulse_width_frame_decoder regression: pass");
		else
			$display("ir_pulse_width_frame_decoder regression: fail");
		$finish;
	end

endmodule
